// ===== sv/wcs_pkg.sv =====
// ----------------------------------------------------------------------------
// wcs_pkg
// Shared types and constants for the wash cycle sequencer.
// ----------------------------------------------------------------------------
package wcs_pkg;

  localparam int unsigned TimeW  = 32;
  localparam int unsigned DurW   = 20;
  localparam int unsigned CfgIdxW = 2;

  // Register map of the configuration port
  localparam logic [CfgIdxW-1:0] CfgFillTime     = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgCleanTime    = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgDrainTimeout = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgDrainSettle  = 2'd3;

  localparam logic [DurW-1:0] FillTimeRst     = 20'd3000;
  localparam logic [DurW-1:0] CleanTimeRst    = 20'd3000;
  localparam logic [DurW-1:0] DrainTimeoutRst = 20'd30000;
  localparam logic [DurW-1:0] DrainSettleRst  = 20'd3000;

  typedef enum logic [2:0] {
    PhIdle    = 3'd0,
    PhFill    = 3'd1,
    PhClean   = 3'd2,
    PhDrain   = 3'd3,
    PhSettle  = 3'd4,
    PhDone    = 3'd5,
    PhPending = 3'd6
  } phase_e;

  typedef enum logic [1:0] {
    DoorNone   = 2'd0,
    DoorOpened = 2'd1,
    DoorClosed = 2'd2
  } door_evt_e;

  // Drive bit positions
  localparam int unsigned DrvFill  = 0;
  localparam int unsigned DrvUs    = 1;
  localparam int unsigned DrvDrain = 2;

  typedef logic [2:0] drive_t;

endpackage

// ===== sv/wash_cycle_sequencer.sv =====
// ----------------------------------------------------------------------------
// wash_cycle_sequencer
// Timed fill / clean / drain / settle sequencer evaluated once per poll.
// ----------------------------------------------------------------------------
// Each transfer on the input channel is one poll; each produces exactly one
// result. A poll is captured in an input register, evaluated by one pass of
// compare logic (a single 32-bit elapsed-time subtract shared by all phases)
// and stored in the result register, so the block takes one poll per clock
// unless the result register stalls. Phases whose end condition already
// holds fall through within the same poll. in_stall_o rises only while the
// result register is full and stalled. Configuration writes take effect at
// once; the user must make them while no poll is in flight (not enforced).
module wash_cycle_sequencer (
  input  logic        clk_i,
  input  logic        rst_ni,
  // poll channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        start_req_i,
  input  logic        door_open_i,
  input  logic        level_high_i,
  input  logic        level_low_i,
  input  logic [31:0] now_ms_i,
  // result channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        fill_valve_o,
  output logic        ultrasonic_o,
  output logic        drain_valve_o,
  output logic [2:0]  phase_o,
  output logic [1:0]  door_event_o,
  output logic        finished_o,
  // configuration
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [19:0] cfg_data_i
);
  import wcs_pkg::*;

  // configuration registers
  logic [DurW-1:0] fill_time_q, clean_time_q, drain_timeout_q, drain_settle_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_time_q     <= FillTimeRst;
      clean_time_q    <= CleanTimeRst;
      drain_timeout_q <= DrainTimeoutRst;
      drain_settle_q  <= DrainSettleRst;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CfgFillTime:     fill_time_q     <= cfg_data_i;
        CfgCleanTime:    clean_time_q    <= cfg_data_i;
        CfgDrainTimeout: drain_timeout_q <= cfg_data_i;
        CfgDrainSettle:  drain_settle_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // input register
  logic             s1_valid_q;
  logic             s1_start_q, s1_door_q, s1_hi_q, s1_lo_q;
  logic [TimeW-1:0] s1_now_q;
  logic             s1_adv;
  logic             in_acc;

  assign s1_adv     = !out_valid_o || !out_stall_i;
  assign in_stall_o = s1_valid_q && !s1_adv;
  assign in_acc     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_adv || !s1_valid_q) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_start_q <= start_req_i;
      s1_door_q  <= door_open_i;
      s1_hi_q    <= level_high_i;
      s1_lo_q    <= level_low_i;
      s1_now_q   <= now_ms_i;
    end
  end

  // sequencer state
  phase_e           phase_q, phase_d;
  logic             last_door_q, last_door_d;
  logic [TimeW-1:0] start_time_q, start_time_d;
  drive_t           drive_q, drive_d;
  door_evt_e        evt;
  logic             fin;
  logic             proc;

  assign proc = s1_valid_q && s1_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PhIdle;
      last_door_q  <= 1'b1;
      start_time_q <= '0;
      drive_q      <= '0;
    end else if (proc) begin
      phase_q      <= phase_d;
      last_door_q  <= last_door_d;
      start_time_q <= start_time_d;
      drive_q      <= drive_d;
    end
  end

  // one evaluation pass; a phase entered in this poll has zero elapsed time
  always_comb begin
    logic             ld;
    logic             fresh;
    logic [TimeW-1:0] el_raw;
    logic [TimeW-1:0] el;

    phase_d      = phase_q;
    drive_d      = drive_q;
    start_time_d = start_time_q;
    fin          = 1'b0;
    fresh        = 1'b0;
    ld           = last_door_q;
    el_raw       = s1_now_q - start_time_q;
    el           = el_raw;

    if (s1_start_q) begin
      ld      = 1'b0;
      phase_d = PhPending;
    end
    if (s1_door_q != ld) begin
      evt = s1_door_q ? DoorOpened : DoorClosed;
    end else begin
      evt = DoorNone;
    end
    last_door_d = s1_door_q;

    if (!s1_door_q) begin
      if (phase_d == PhPending) begin
        drive_d[DrvFill] = 1'b1;
        start_time_d     = s1_now_q;
        phase_d          = PhFill;
        fresh            = 1'b1;
      end
      el = fresh ? '0 : el_raw;
      if (phase_d == PhFill) begin
        if (el >= TimeW'(fill_time_q) || s1_hi_q) begin
          drive_d[DrvFill] = 1'b0;
          drive_d[DrvUs]   = 1'b1;
          start_time_d     = s1_now_q;
          phase_d          = PhClean;
          fresh            = 1'b1;
        end
      end
      el = fresh ? '0 : el_raw;
      if (phase_d == PhClean) begin
        if (el >= TimeW'(clean_time_q)) begin
          drive_d[DrvUs]    = 1'b0;
          drive_d[DrvDrain] = 1'b1;
          start_time_d      = s1_now_q;
          phase_d           = PhDrain;
          fresh             = 1'b1;
        end
      end
      el = fresh ? '0 : el_raw;
      if (phase_d == PhDrain) begin
        if (s1_lo_q || el >= TimeW'(drain_timeout_q)) begin
          start_time_d = s1_now_q;
          phase_d      = PhSettle;
          fresh        = 1'b1;
        end
      end
      el = fresh ? '0 : el_raw;
      if (phase_d == PhSettle) begin
        if (el >= TimeW'(drain_settle_q)) begin
          drive_d[DrvDrain] = 1'b0;
          phase_d           = PhDone;
          fin               = 1'b1;
        end
      end
    end
  end

  // reported phase: a pending fill reads as filling
  logic [2:0] phase_rep;
  always_comb begin
    case (phase_d)
      PhPending: phase_rep = PhFill;
      PhIdle, PhFill, PhClean, PhDrain, PhSettle, PhDone: phase_rep = phase_d;
      default:   phase_rep = PhIdle;
    endcase
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (s1_adv) begin
      out_valid_o <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc) begin
      fill_valve_o  <= drive_d[DrvFill];
      ultrasonic_o  <= drive_d[DrvUs];
      drain_valve_o <= drive_d[DrvDrain];
      phase_o       <= phase_rep;
      door_event_o  <= evt;
      finished_o    <= fin;
    end
  end

  // assertions
  a_fin_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && finished_o |-> phase_o == PhDone && !drain_valve_o)
    else $error("finished without done phase or with drain open");

  a_proc_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc |=> out_valid_o)
    else $error("evaluated poll produced no result");

  a_state_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !proc |=> $stable(phase_q) && $stable(drive_q) && $stable(start_time_q))
    else $error("sequencer state changed without a poll");

  a_door_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc && s1_door_q && !s1_start_q |=> $stable(drive_q) && $stable(start_time_q))
    else $error("drives or timer changed while door open");

endmodule
